// ===== hw/rtl/gcsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsa_pkg - shared types and constants of the grid cell statistics block
// Command, status and register codes, the queued operation record, the
// grid geometry, per-cell statistics and result records and a saturating increment.
// ----------------------------------------------------------------------------
package gcsa_pkg;

    // request commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOR     = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;
    localparam logic [1:0] ST_BAD_VAL = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_END_X      = 3'd2;
    localparam logic [2:0] CFG_END_Y      = 3'd3;
    localparam logic [2:0] CFG_INV_CELL_W = 3'd4;
    localparam logic [2:0] CFG_INV_CELL_H = 3'd5;
    localparam logic [2:0] CFG_CELLS_WIDE = 3'd6;
    localparam logic [2:0] CFG_CELLS_HIGH = 3'd7;

    // classified operation kinds
    typedef enum logic [2:0] {
        K_NOP      = 3'd0,
        K_ADD_OK   = 3'd1,
        K_ADD_BAD  = 3'd2,
        K_BAD_POS  = 3'd3,
        K_OOR      = 3'd4,
        K_READ     = 3'd5,
        K_READ_OOR = 3'd6,
        K_CLEAR    = 3'd7
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] value;
    } op_t;

    // grid geometry registers seen by the front end
    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [31:0] inv_w;
        logic [31:0] inv_h;
    } geom_t;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] bad;
        logic [31:0] vmin;
        logic [31:0] vmax;
        logic [47:0] mean;
        logic [63:0] m2;
    } cell_t;

    localparam cell_t CELL_RESET = '{
        count: 32'd0,
        bad:   32'd0,
        vmin:  32'h7FFF_FFFF,
        vmax:  32'h8000_0000,
        mean:  48'd0,
        m2:    64'd0
    };

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  col;
        logic [7:0]  row;
        cell_t       stats;
        logic [31:0] added;
        logic [31:0] oor;
        logic [31:0] bad;
    } result_t;

    // saturating counter increment
    function automatic logic [31:0] inc_sat(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

endpackage

// ===== hw/rtl/grid_cell_stats_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_stats_accumulator - binned per-cell running statistics
// Bins (x, y, v) samples into a grid of cells and keeps count, invalid
// count, min, max, running mean and M2 per cell, plus global totals.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    cmd, pos_x, pos_y, sample_value,
//                                    pos_bad, value_bad, read_col, read_row
//   out       out_valid / out_ready  status, col, row, cell fields, totals
//   cfg       cfg_wr_en              cfg_index, cfg_wdata
//
// An add of a valid value runs through the divider (two quotient bits a
// cycle) and the partial-product multiplier in the cell engine; other
// requests use neither. After reset, and on a clear request, a sweep
// writes every cell back to its reset value, one cell a cycle; no request
// is taken during the sweep after reset.
// The front end keeps accepting while a result waits on out_ready, until
// the operation queue is full.
// ----------------------------------------------------------------------------
module grid_cell_stats_accumulator #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] sample_value,
    input  logic               pos_bad,
    input  logic               value_bad,
    input  logic [7:0]         read_col,
    input  logic [7:0]         read_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         col,
    output logic [7:0]         row,
    output logic [31:0]        valid_count,
    output logic [31:0]        invalid_count,
    output logic signed [31:0] cell_min,
    output logic signed [31:0] cell_max,
    output logic signed [47:0] cell_mean,
    output logic [63:0]        cell_m2,
    output logic [31:0]        total_added,
    output logic [31:0]        total_oor,
    output logic [31:0]        total_invalid,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int OPW = $bits(gcsa_pkg::op_t);

    gcsa_pkg::geom_t    geom_reg;
    logic [8:0]         cells_wide_reg, cells_high_reg;
    logic [CW-1:0]      col_last;
    logic [RW-1:0]      row_last;
    logic               init_busy, q_full, q_push, q_pop, q_valid;
    gcsa_pkg::op_t      f_op, b_op;
    logic [AW-1:0]      f_addr, b_addr;
    logic [OPW+AW-1:0]  q_head;
    gcsa_pkg::result_t  res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.origin_x <= '0;
            geom_reg.origin_y <= '0;
            geom_reg.end_x    <= '0;
            geom_reg.end_y    <= '0;
            geom_reg.inv_w    <= 32'd65536;
            geom_reg.inv_h    <= 32'd65536;
            cells_wide_reg    <= 9'd256;
            cells_high_reg    <= 9'd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gcsa_pkg::CFG_ORIGIN_X:   geom_reg.origin_x <= cfg_wdata;
                gcsa_pkg::CFG_ORIGIN_Y:   geom_reg.origin_y <= cfg_wdata;
                gcsa_pkg::CFG_END_X:      geom_reg.end_x    <= cfg_wdata;
                gcsa_pkg::CFG_END_Y:      geom_reg.end_y    <= cfg_wdata;
                gcsa_pkg::CFG_INV_CELL_W: geom_reg.inv_w    <= cfg_wdata;
                gcsa_pkg::CFG_INV_CELL_H: geom_reg.inv_h    <= cfg_wdata;
                gcsa_pkg::CFG_CELLS_WIDE: cells_wide_reg    <= cfg_wdata[8:0];
                gcsa_pkg::CFG_CELLS_HIGH: cells_high_reg    <= cfg_wdata[8:0];
            endcase
        end
    end

    // last column and row in use, zero acting as one and capped at the maximum
    always_comb
    begin
        if (cells_wide_reg == 9'd0)
            col_last = '0;
        else if (32'(cells_wide_reg) > 32'(MAX_COLS))
            col_last = CW'(MAX_COLS - 1);
        else
            col_last = CW'(cells_wide_reg - 9'd1);

        if (cells_high_reg == 9'd0)
            row_last = '0;
        else if (32'(cells_high_reg) > 32'(MAX_ROWS))
            row_last = RW'(MAX_ROWS - 1);
        else
            row_last = RW'(cells_high_reg - 9'd1);
    end

    gcsa_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .sample_value (sample_value),
        .pos_bad      (pos_bad),
        .value_bad    (value_bad),
        .read_col     (read_col),
        .read_row     (read_row),
        .geom         (geom_reg),
        .col_last     (col_last),
        .row_last     (row_last),
        .hold         (init_busy),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (f_op),
        .q_addr       (f_addr)
    );

    gcsa_queue #(
        .WIDTH (OPW + AW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_op, f_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign b_op   = q_head[OPW+AW-1:AW];
    assign b_addr = q_head[AW-1:0];

    gcsa_back #(
        .CELLS (CELLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (b_op),
        .q_addr    (b_addr),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    // result fields
    assign status        = res.status;
    assign col           = res.col;
    assign row           = res.row;
    assign valid_count   = res.stats.count;
    assign invalid_count = res.stats.bad;
    assign cell_min      = $signed(res.stats.vmin);
    assign cell_max      = $signed(res.stats.vmax);
    assign cell_mean     = $signed(res.stats.mean);
    assign cell_m2       = res.stats.m2;
    assign total_added   = res.added;
    assign total_oor     = res.oor;
    assign total_invalid = res.bad;

endmodule

// ===== hw/rtl/gcsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsa_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/gcsa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsa_queue - short operation queue
// Small FIFO that decouples the classifying front end from the cell engine.
// ----------------------------------------------------------------------------
module gcsa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/gcsa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsa_front - request intake and classification
// Accepts a request, checks position and value, maps the position to a
// cell through the inverse cell size and queues the classified operation.
// ----------------------------------------------------------------------------
module gcsa_front #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int AW = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    sample_value,
    input  logic                  pos_bad,
    input  logic                  value_bad,
    input  logic [7:0]            read_col,
    input  logic [7:0]            read_row,
    input  gcsa_pkg::geom_t       geom,
    input  logic [CW-1:0]         col_last,
    input  logic [RW-1:0]         row_last,
    input  logic                  hold,
    input  logic                  q_full,
    output logic                  q_push,
    output gcsa_pkg::op_t         q_op,
    output logic [AW-1:0]         q_addr
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t              state_reg, state_next;
    gcsa_pkg::op_kind_t   kind_reg, kind_in;
    logic [31:0]          offx_reg, offy_reg, value_reg;
    logic [7:0]           rcol_reg, rrow_reg;
    logic [31:0]          idx_x_reg, idx_y_reg;
    logic [63:0]          prod_x, prod_y;
    logic                 out_of_grid, accept, is_read;
    logic [CW-1:0]        col_sel;
    logic [RW-1:0]        row_sel;

    assign in_ready = (state_reg == F_IDLE) && !hold;
    assign accept   = in_valid && in_ready;

    // bounds check against the grid edges
    assign out_of_grid = (pos_x < $signed(geom.origin_x)) || (pos_x > $signed(geom.end_x)) ||
                         (pos_y < $signed(geom.origin_y)) || (pos_y > $signed(geom.end_y));

    // classify the incoming request
    always_comb
    begin
        unique case (cmd)
            gcsa_pkg::CMD_ADD:
            begin
                priority if (pos_bad)
                    kind_in = gcsa_pkg::K_BAD_POS;
                else if (out_of_grid)
                    kind_in = gcsa_pkg::K_OOR;
                else if (value_bad)
                    kind_in = gcsa_pkg::K_ADD_BAD;
                else
                    kind_in = gcsa_pkg::K_ADD_OK;
            end
            gcsa_pkg::CMD_READ:
            begin
                if ((32'(read_col) <= 32'(col_last)) && (32'(read_row) <= 32'(row_last)))
                    kind_in = gcsa_pkg::K_READ;
                else
                    kind_in = gcsa_pkg::K_READ_OOR;
            end
            gcsa_pkg::CMD_CLEAR:
            begin
                kind_in = gcsa_pkg::K_CLEAR;
            end
            default:
            begin
                kind_in = gcsa_pkg::K_NOP;
            end
        endcase
    end

    // position to cell scaling
    assign prod_x = offx_reg * geom.inv_w;
    assign prod_y = offy_reg * geom.inv_h;

    // cap at the last cell in use, or take the read coordinates
    assign is_read = (kind_reg == gcsa_pkg::K_READ) || (kind_reg == gcsa_pkg::K_READ_OOR);
    always_comb
    begin
        if (is_read)
        begin
            col_sel = CW'(rcol_reg);
            row_sel = RW'(rrow_reg);
        end
        else
        begin
            col_sel = (idx_x_reg > 32'(col_last)) ? col_last : CW'(idx_x_reg);
            row_sel = (idx_y_reg > 32'(row_last)) ? row_last : RW'(idx_y_reg);
        end
    end

    assign q_addr      = AW'(32'(row_sel) * 32'(MAX_COLS) + 32'(col_sel));
    assign q_op.kind   = kind_reg;
    assign q_op.col    = is_read ? rcol_reg : 8'(col_sel);
    assign q_op.row    = is_read ? rrow_reg : 8'(row_sel);
    assign q_op.value  = value_reg;
    assign q_push      = (state_reg == F_PUSH);

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_MUL;
            end
            F_MUL:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            kind_reg  <= gcsa_pkg::K_NOP;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                kind_reg <= kind_in;
        end
    end

    // request payload and scaled indexes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offx_reg  <= 32'(pos_x - $signed(geom.origin_x));
            offy_reg  <= 32'(pos_y - $signed(geom.origin_y));
            value_reg <= sample_value;
            rcol_reg  <= read_col;
            rrow_reg  <= read_row;
        end
        if (state_reg == F_MUL)
        begin
            idx_x_reg <= prod_x[63:32];
            idx_y_reg <= prod_y[63:32];
        end
    end

endmodule

// ===== hw/rtl/gcsa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsa_back - cell statistics engine
// Runs queued operations against the cell memory: read-modify-write with a
// two-bit-per-cycle divider for the mean and a split multiplier for M2,
// global totals, clearing sweeps and the output register.
// ----------------------------------------------------------------------------
module gcsa_back #(
    parameter int CELLS = 65536,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  gcsa_pkg::op_t       q_op,
    input  logic [AW-1:0]       q_addr,
    output logic                q_pop,
    output logic                init_busy,
    output logic                out_valid,
    input  logic                out_ready,
    output gcsa_pkg::result_t   out_res
);

    localparam int DIV_CYCLES = 24;
    localparam logic [4:0] DIV_LAST = 5'(DIV_CYCLES - 1);

    typedef enum logic [6:0] {
        B_CLEAR = 7'b0000001,
        B_IDLE  = 7'b0000010,
        B_WAIT  = 7'b0000100,
        B_DIV   = 7'b0001000,
        B_FIX   = 7'b0010000,
        B_MUL   = 7'b0100000,
        B_OUT   = 7'b1000000
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic                 init_reg, init_next;
    logic                 out_valid_reg, out_valid_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [4:0]           div_cnt_reg, div_cnt_next;
    logic [1:0]           mul_cnt_reg, mul_cnt_next;
    logic [31:0]          added_reg, added_next;
    logic [31:0]          oor_reg, oor_next;
    logic [31:0]          bad_reg, bad_next;

    gcsa_pkg::op_t        op_reg, op_next;
    logic [AW-1:0]        addr_reg, addr_next;
    gcsa_pkg::cell_t      cell_reg, cell_next;
    logic [1:0]           status_reg, status_next;
    logic [7:0]           col_reg, col_next;
    logic [7:0]           row_reg, row_next;
    logic [31:0]          n_reg, n_next;
    logic                 neg_reg, neg_next;
    logic [47:0]          mag_reg, mag_next;
    logic [47:0]          mag2_reg, mag2_next;
    logic [47:0]          quo_reg, quo_next;
    logic [31:0]          rem_reg, rem_next;
    logic [95:0]          acc_reg, acc_next;
    gcsa_pkg::result_t    res_reg, res_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    gcsa_pkg::cell_t      ram_wdata, ram_rdata;

    gcsa_ram #(
        .WIDTH ($bits(gcsa_pkg::cell_t)),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign init_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // operation sequencer and datapath
    always_comb
    begin
        gcsa_pkg::cell_t    c;
        logic signed [48:0] vq, mean_s, delta, qs, nm, delta2;
        logic [32:0]        rem_s;
        logic [31:0]        rem_t, opa, opb;
        logic [47:0]        quo_t;
        logic [63:0]        pp;
        logic [95:0]        pp_sh, acc_t;
        logic [64:0]        m2_sum;

        state_next     = state_reg;
        init_next      = init_reg;
        out_valid_next = out_valid_reg && !out_ready;
        clr_addr_next  = clr_addr_reg;
        div_cnt_next   = div_cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        added_next     = added_reg;
        oor_next       = oor_reg;
        bad_next       = bad_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        cell_next      = cell_reg;
        status_next    = status_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        mag2_next      = mag2_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = cell_reg;
        ram_re    = 1'b0;
        ram_raddr = q_addr;

        c      = cell_reg;
        vq     = $signed({op_reg.value[31], op_reg.value, 16'd0});
        mean_s = $signed({cell_reg.mean[47], cell_reg.mean});
        delta  = '0;
        qs     = '0;
        nm     = '0;
        delta2 = '0;
        rem_s  = '0;
        rem_t  = rem_reg;
        quo_t  = quo_reg;
        opa    = mul_cnt_reg[1] ? {16'd0, mag_reg[47:32]} : mag_reg[31:0];
        opb    = mul_cnt_reg[0] ? {16'd0, mag2_reg[47:32]} : mag2_reg[31:0];
        pp     = opa * opb;
        pp_sh  = '0;
        acc_t  = '0;
        m2_sum = '0;

        unique case (state_reg)
            // sweep every cell back to its reset value
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = gcsa_pkg::CELL_RESET;
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_OUT;
                    end
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            // take the next queued operation
            B_IDLE:
            begin
                if (q_valid)
                begin
                    op_next     = q_op;
                    addr_next   = q_addr;
                    cell_next   = '0;
                    status_next = gcsa_pkg::ST_OK;
                    col_next    = 8'd0;
                    row_next    = 8'd0;
                    unique case (q_op.kind)
                        gcsa_pkg::K_ADD_OK,
                        gcsa_pkg::K_ADD_BAD,
                        gcsa_pkg::K_READ:
                        begin
                            ram_re     = 1'b1;
                            col_next   = q_op.col;
                            row_next   = q_op.row;
                            state_next = B_WAIT;
                        end
                        gcsa_pkg::K_BAD_POS:
                        begin
                            bad_next    = gcsa_pkg::inc_sat(bad_reg);
                            status_next = gcsa_pkg::ST_BAD_POS;
                            state_next  = B_OUT;
                        end
                        gcsa_pkg::K_OOR:
                        begin
                            oor_next    = gcsa_pkg::inc_sat(oor_reg);
                            status_next = gcsa_pkg::ST_OOR;
                            state_next  = B_OUT;
                        end
                        gcsa_pkg::K_READ_OOR:
                        begin
                            status_next = gcsa_pkg::ST_OOR;
                            col_next    = q_op.col;
                            row_next    = q_op.row;
                            state_next  = B_OUT;
                        end
                        gcsa_pkg::K_CLEAR:
                        begin
                            added_next    = '0;
                            oor_next      = '0;
                            bad_next      = '0;
                            clr_addr_next = '0;
                            state_next    = B_CLEAR;
                        end
                        gcsa_pkg::K_NOP:
                        begin
                            state_next = B_OUT;
                        end
                    endcase
                end
            end

            // cell data is back from memory
            B_WAIT:
            begin
                c = ram_rdata;
                unique case (op_reg.kind)
                    gcsa_pkg::K_READ:
                    begin
                        cell_next  = c;
                        state_next = B_OUT;
                    end
                    gcsa_pkg::K_ADD_BAD:
                    begin
                        c.bad       = gcsa_pkg::inc_sat(c.bad);
                        bad_next    = gcsa_pkg::inc_sat(bad_reg);
                        ram_we      = 1'b1;
                        ram_wdata   = c;
                        cell_next   = c;
                        status_next = gcsa_pkg::ST_BAD_VAL;
                        state_next  = B_OUT;
                    end
                    gcsa_pkg::K_ADD_OK:
                    begin
                        mean_s = $signed({c.mean[47], c.mean});
                        if ($signed(op_reg.value) < $signed(c.vmin))
                            c.vmin = op_reg.value;
                        if ($signed(op_reg.value) > $signed(c.vmax))
                            c.vmax = op_reg.value;
                        c.count      = gcsa_pkg::inc_sat(c.count);
                        n_next       = c.count;
                        delta        = vq - mean_s;
                        neg_next     = delta[48];
                        mag_next     = delta[48] ? 48'(-delta) : delta[47:0];
                        quo_next     = delta[48] ? 48'(-delta) : delta[47:0];
                        rem_next     = '0;
                        div_cnt_next = '0;
                        added_next   = gcsa_pkg::inc_sat(added_reg);
                        cell_next    = c;
                        state_next   = B_DIV;
                    end
                    default:
                    begin
                        state_next = B_OUT;
                    end
                endcase
            end

            // restoring divide, two quotient bits a cycle
            B_DIV:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    rem_s = {rem_t, quo_t[47]};
                    quo_t = {quo_t[46:0], 1'b0};
                    if (rem_s >= {1'b0, n_reg})
                    begin
                        rem_s    = rem_s - {1'b0, n_reg};
                        quo_t[0] = 1'b1;
                    end
                    rem_t = rem_s[31:0];
                end
                rem_next = rem_t;
                quo_next = quo_t;
                if (div_cnt_reg == DIV_LAST)
                    state_next = B_FIX;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end

            // signed quotient, new mean and second deviation
            B_FIX:
            begin
                qs             = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
                nm             = mean_s + qs;
                delta2         = vq - nm;
                mag2_next      = delta2[48] ? 48'(-delta2) : delta2[47:0];
                cell_next.mean = nm[47:0];
                acc_next       = '0;
                mul_cnt_next   = '0;
                state_next     = B_MUL;
            end

            // deviation product, one partial product a cycle
            B_MUL:
            begin
                unique case (mul_cnt_reg)
                    2'd0:    pp_sh = {32'd0, pp};
                    2'd1:    pp_sh = {pp, 32'd0};
                    2'd2:    pp_sh = {pp, 32'd0};
                    default: pp_sh = {pp[31:0], 64'd0};
                endcase
                acc_t    = acc_reg + pp_sh;
                acc_next = acc_t;
                if (mul_cnt_reg == 2'd3)
                begin
                    m2_sum      = {1'b0, cell_reg.m2} + {1'b0, acc_t[95:32]};
                    c.m2        = m2_sum[64] ? '1 : m2_sum[63:0];
                    cell_next   = c;
                    ram_we      = 1'b1;
                    ram_wdata   = c;
                    status_next = gcsa_pkg::ST_OK;
                    state_next  = B_OUT;
                end
                else
                begin
                    mul_cnt_next = mul_cnt_reg + 1'b1;
                end
            end

            // hand the result to the output register
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.status = status_reg;
                    res_next.col    = col_reg;
                    res_next.row    = row_reg;
                    res_next.stats  = cell_reg;
                    res_next.added  = added_reg;
                    res_next.oor    = oor_reg;
                    res_next.bad    = bad_reg;
                    out_valid_next  = 1'b1;
                    state_next      = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            div_cnt_reg   <= '0;
            mul_cnt_reg   <= '0;
            added_reg     <= '0;
            oor_reg       <= '0;
            bad_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            clr_addr_reg  <= clr_addr_next;
            div_cnt_reg   <= div_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            added_reg     <= added_next;
            oor_reg       <= oor_next;
            bad_reg       <= bad_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        cell_reg   <= cell_next;
        status_reg <= status_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        n_reg      <= n_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        mag2_reg   <= mag2_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

endmodule

// ===== tb/sv/tb_grid_cell_stats_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cell_stats_accumulator - grid cell statistics block testbench
// Sends add, read, clear and undefined-command requests under several grid
// set-ups, predicts every result with a sparse per-cell model and checks each
// field, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_grid_cell_stats_accumulator;

    localparam int NCOLS_MAX = 256;
    localparam int NROWS_MAX = 256;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = gcsa_pkg::CMD_ADD;
    logic signed [31:0] pos_x = '0, pos_y = '0, sample_value = '0;
    logic pos_bad = 1'b0, value_bad = 1'b0;
    logic [7:0] read_col = '0, read_row = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] col, row;
    logic [31:0] valid_count, invalid_count;
    logic signed [31:0] cell_min, cell_max;
    logic signed [47:0] cell_mean;
    logic [63:0] cell_m2;
    logic [31:0] total_added, total_oor, total_invalid;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = gcsa_pkg::CFG_ORIGIN_X;
    logic [31:0] cfg_wdata = '0;

    grid_cell_stats_accumulator u_top (.*);

    always #6 clk = ~clk;

    // grid settings as last written
    logic signed [31:0] g_org_x, g_org_y, g_end_x, g_end_y;
    logic [31:0] g_inv_w, g_inv_h;
    logic [8:0] g_wide, g_high;

    // sparse cell stores; a missing entry means a cleared cell
    gcsa_pkg::cell_t cells[int];
    logic [31:0] n_added, n_oor, n_bad;

    gcsa_pkg::result_t expected_q[$];
    int errors = 0;
    bit hold_output = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    function automatic int dim_eff(input logic [8:0] n, input int maxv);
        if (n == 0) return 1;
        return (n > maxv) ? maxv : n;
    endfunction

    function automatic logic [31:0] axis_index(input logic signed [31:0] p,
                                               input logic signed [31:0] o,
                                               input logic [31:0] inv, input int n);
        logic [63:0] off;
        logic [95:0] prod;
        logic [63:0] idx;
        off = 64'(64'(signed'(p)) - 64'(signed'(o)));
        prod = 96'(off) * 96'(inv);
        idx = prod[95:32];
        return (idx > 64'(n - 1)) ? 32'(n - 1) : idx[31:0];
    endfunction

    function automatic gcsa_pkg::cell_t cell_get(input int a);
        return cells.exists(a) ? cells[a] : gcsa_pkg::CELL_RESET;
    endfunction

    // statistics update of one request; returns the expected result
    function automatic gcsa_pkg::result_t predict_stats(input logic [1:0] c,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] v, input logic pb, input logic vb,
            input logic [7:0] rc, input logic [7:0] rr);
        gcsa_pkg::result_t r;
        int nc, nr, a;
        logic [31:0] ci, ri;
        gcsa_pkg::cell_t ce;
        logic signed [63:0] vq, mean, delta, nm, delta2;
        logic [63:0] ud, ud2, inc;
        logic [127:0] prod;
        logic [64:0] sum;
        r = '0;
        nc = dim_eff(g_wide, NCOLS_MAX);
        nr = dim_eff(g_high, NROWS_MAX);
        if (c == gcsa_pkg::CMD_ADD)
        begin
            if (pb)
            begin
                n_bad = gcsa_pkg::inc_sat(n_bad);
                r.status = gcsa_pkg::ST_BAD_POS;
            end
            else if (px < g_org_x || px > g_end_x || py < g_org_y || py > g_end_y)
            begin
                n_oor = gcsa_pkg::inc_sat(n_oor);
                r.status = gcsa_pkg::ST_OOR;
            end
            else
            begin
                ci = axis_index(px, g_org_x, g_inv_w, nc);
                ri = axis_index(py, g_org_y, g_inv_h, nr);
                a = ri * NCOLS_MAX + ci;
                r.col = ci[7:0];
                r.row = ri[7:0];
                ce = cell_get(a);
                if (vb)
                begin
                    n_bad = gcsa_pkg::inc_sat(n_bad);
                    ce.bad = gcsa_pkg::inc_sat(ce.bad);
                    r.status = gcsa_pkg::ST_BAD_VAL;
                end
                else
                begin
                    if (v < signed'(ce.vmin)) ce.vmin = v;
                    if (v > signed'(ce.vmax)) ce.vmax = v;
                    ce.count = gcsa_pkg::inc_sat(ce.count);
                    vq = 64'(v) <<< 16;
                    mean = 64'(signed'(ce.mean));
                    delta = vq - mean;
                    nm = mean + delta / signed'({32'd0, ce.count});
                    delta2 = vq - nm;
                    ud = delta < 0 ? -delta : delta;
                    ud2 = delta2 < 0 ? -delta2 : delta2;
                    prod = 128'(ud) * 128'(ud2);
                    inc = (prod[127:96] != 0) ? '1 : prod[95:32];
                    sum = 65'(ce.m2) + 65'(inc);
                    ce.m2 = sum[64] ? '1 : sum[63:0];
                    ce.mean = nm[47:0];
                    n_added = gcsa_pkg::inc_sat(n_added);
                    r.status = gcsa_pkg::ST_OK;
                end
                cells[a] = ce;
                r.stats = ce;
            end
        end
        else if (c == gcsa_pkg::CMD_READ)
        begin
            r.col = rc;
            r.row = rr;
            if (rc >= nc || rr >= nr) r.status = gcsa_pkg::ST_OOR;
            else r.stats = cell_get(rr * NCOLS_MAX + rc);
        end
        else if (c == gcsa_pkg::CMD_CLEAR)
        begin
            cells.delete();
            n_added = '0;
            n_oor = '0;
            n_bad = '0;
        end
        r.added = n_added;
        r.oor = n_oor;
        r.bad = n_bad;
        return r;
    endfunction

    // valid stays high into the next request when there is no gap
    task automatic send_request(input logic [1:0] c, input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] v, input logic pb,
            input logic vb, input logic [7:0] rc, input logic [7:0] rr);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        pos_x <= px;
        pos_y <= py;
        sample_value <= v;
        pos_bad <= pb;
        value_bad <= vb;
        read_col <= rc;
        read_row <= rr;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(predict_stats(c, px, py, v, pb, vb, rc, rr));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            gcsa_pkg::CFG_ORIGIN_X:   g_org_x = val;
            gcsa_pkg::CFG_ORIGIN_Y:   g_org_y = val;
            gcsa_pkg::CFG_END_X:      g_end_x = val;
            gcsa_pkg::CFG_END_Y:      g_end_y = val;
            gcsa_pkg::CFG_INV_CELL_W: g_inv_w = val;
            gcsa_pkg::CFG_INV_CELL_H: g_inv_h = val;
            gcsa_pkg::CFG_CELLS_WIDE: g_wide = val[8:0];
            default:                  g_high = val[8:0];
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] ex,
            input logic [31:0] ey, input logic [31:0] iw, input logic [31:0] ih,
            input logic [31:0] w, input logic [31:0] h);
        drain();
        write_reg(gcsa_pkg::CFG_ORIGIN_X, ox);
        write_reg(gcsa_pkg::CFG_ORIGIN_Y, oy);
        write_reg(gcsa_pkg::CFG_END_X, ex);
        write_reg(gcsa_pkg::CFG_END_Y, ey);
        write_reg(gcsa_pkg::CFG_INV_CELL_W, iw);
        write_reg(gcsa_pkg::CFG_INV_CELL_H, ih);
        write_reg(gcsa_pkg::CFG_CELLS_WIDE, w);
        write_reg(gcsa_pkg::CFG_CELLS_HIGH, h);
    endtask

    // position mostly inside the grid, edges favoured now and then
    function automatic logic [31:0] pick_pos(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
        logic [63:0] span;
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            2: return $urandom();
            default:
            begin
                span = 64'(64'(signed'(hi)) - 64'(signed'(lo)));
                return 32'(64'(signed'(lo)) + ({$urandom(), $urandom()} % (span + 1)));
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'(signed'($urandom_range(0, 2000))) - 1000;
        endcase
    endfunction

    task automatic random_requests(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 70)
                send_request(gcsa_pkg::CMD_ADD, pick_pos(g_org_x, g_end_x),
                             pick_pos(g_org_y, g_end_y), pick_value(),
                             $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0,
                             8'd0, 8'd0);
            else if (sel < 96)
                send_request(gcsa_pkg::CMD_READ, $urandom(), $urandom(), $urandom(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)),
                             ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 3)));
            else if (sel < 98)
                send_request(gcsa_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(),
                             1'b0, 1'b0, 8'd0, 8'd0);
            else
                send_request(2'd3, $urandom(), $urandom(), $urandom(), 1'b0, 1'b0,
                             8'($urandom()), 8'($urandom()));
        end
    endtask

    task automatic test_directed();
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 32'h0004_0000,
                 32'h0001_0000, 32'h0001_0000, 4, 4);
        // two samples in one cell, then the extremes of the value
        send_request(gcsa_pkg::CMD_ADD, 32'h0001_8000, 32'h0002_0000, 32'h0003_0000,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h0001_0000, 32'h0002_FFFF, 32'hFFFF_0000,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000,
                     1'b0, 1'b0, 8'd0, 8'd0);
        // far edge is capped to the last cell
        send_request(gcsa_pkg::CMD_ADD, 32'h0004_0000, 32'h0004_0000, 32'h0000_0001,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     1'b0, 1'b1, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     1'b1, 1'b1, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h0000_0000, 32'h0004_0001, 32'h0000_0000,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                     1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_READ, 0, 0, 0, 1'b0, 1'b0, 8'd1, 8'd2);
        send_request(gcsa_pkg::CMD_READ, 0, 0, 0, 1'b0, 1'b0, 8'd3, 8'd3);
        send_request(gcsa_pkg::CMD_READ, 0, 0, 0, 1'b0, 1'b0, 8'd4, 8'd0);
        send_request(gcsa_pkg::CMD_READ, 0, 0, 0, 1'b0, 1'b0, 8'd255, 8'd255);
        send_request(2'd3, 0, 0, 0, 1'b0, 1'b0, 8'd1, 8'd2);
        send_request(gcsa_pkg::CMD_CLEAR, 0, 0, 0, 1'b0, 1'b0, 8'd0, 8'd0);
        send_request(gcsa_pkg::CMD_READ, 0, 0, 0, 1'b0, 1'b0, 8'd1, 8'd2);
    endtask

    task automatic test_full_range_grid();
        // whole coordinate range, largest grid, huge cells
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h0000_0100, 32'h0000_0100, 256, 256);
        random_requests(150);
        // zero and oversized grid sizes, maximum inverse size
        set_grid(32'h8000_0000, 32'hFFF0_0000, 32'h7FFF_FFFF, 32'h0010_0000,
                 32'hFFFF_FFFF, 32'h0000_0000, 0, 511);
        random_requests(100);
    endtask

    task automatic test_small_grid();
        set_grid(32'hFFFE_0000, 32'h0000_0000, 32'h0002_0000, 32'h0001_0000,
                 32'h0000_8000, 32'h0004_0000, 3, 4);
        random_requests(350);
    endtask

    task automatic test_inverted_grid();
        set_grid(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                 32'h0001_0000, 32'h0001_0000, 256, 1);
        random_requests(60);
    endtask

    task automatic test_output_stall();
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 32'h0002_0000,
                 32'h0001_0000, 32'h0001_0000, 2, 2);
        fork
            begin
                hold_output = 1'b1;
                repeat (600) @(posedge clk);
                hold_output = 1'b0;
            end
            random_requests(40);
        join
        random_requests(250);
    endtask

    // receiver: random stalls and result comparison
    initial
    begin
        int wait_cycles;
        gcsa_pkg::result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report("unexpected result", status, 0);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (status !== exp_r.status) report("status", status, exp_r.status);
                    if (col !== exp_r.col) report("col", col, exp_r.col);
                    if (row !== exp_r.row) report("row", row, exp_r.row);
                    if (valid_count !== exp_r.stats.count)
                        report("valid_count", valid_count, exp_r.stats.count);
                    if (invalid_count !== exp_r.stats.bad)
                        report("invalid_count", invalid_count, exp_r.stats.bad);
                    if (cell_min !== exp_r.stats.vmin)
                        report("cell_min", cell_min, exp_r.stats.vmin);
                    if (cell_max !== exp_r.stats.vmax)
                        report("cell_max", cell_max, exp_r.stats.vmax);
                    if (cell_mean !== exp_r.stats.mean)
                        report("cell_mean", cell_mean, exp_r.stats.mean);
                    if (cell_m2 !== exp_r.stats.m2) report("cell_m2", cell_m2, exp_r.stats.m2);
                    if (total_added !== exp_r.added)
                        report("total_added", total_added, exp_r.added);
                    if (total_oor !== exp_r.oor) report("total_oor", total_oor, exp_r.oor);
                    if (total_invalid !== exp_r.bad)
                        report("total_invalid", total_invalid, exp_r.bad);
                end
                out_ready <= 1'b0;
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
            else if (!out_ready)
            begin
                if (hold_output) wait_cycles = 1;
                else if (wait_cycles > 0) wait_cycles--;
                else out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        g_org_x = 0; g_org_y = 0; g_end_x = 0; g_end_y = 0;
        g_inv_w = 32'h0001_0000; g_inv_h = 32'h0001_0000;
        g_wide = 9'd256; g_high = 9'd256;
        n_added = 0; n_oor = 0; n_bad = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_range_grid();
        test_small_grid();
        test_inverted_grid();
        test_output_stall();
        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // each clear sweeps the whole cell memory, so allow plenty of time
    initial
    begin
        #300ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
